// ----- rtl/csvft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Shared constants, result and packet types, and a helper function.
// ----------------------------------------------------------------------------
package csvft_pkg;

    localparam int FIELD_INDEX_BITS = 16;
    localparam int RES_MAX          = 3;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_BITS        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
    localparam logic [6:0] DELIM_RESET    = 7'd44;
    localparam logic [6:0] QUOTE_RESET    = 7'd34;

    localparam logic [7:0] UTF8_LEAD2_LO = 8'hC2;
    localparam logic [7:0] UTF8_LEAD2_HI = 8'hDF;
    localparam logic [7:0] UTF8_LEAD3_LO = 8'hE0;
    localparam logic [7:0] UTF8_LEAD3_HI = 8'hEF;
    localparam logic [7:0] UTF8_LEAD4_LO = 8'hF0;
    localparam logic [7:0] UTF8_LEAD4_HI = 8'hF4;
    localparam logic [1:0] UTF8_CONT_TAG = 2'b10;

    typedef enum logic {
        CFG_DELIMITER = 1'b0,
        CFG_QUOTE     = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       field_end;
        logic       utf8_error;
    } t_res;

    typedef struct packed {
        t_res [RES_MAX-1:0] res;
        logic [1:0]         cnt;
        logic [15:0]        field_number;
    } t_pkt;

    function automatic logic [15:0] sat_field(input logic [FIELD_INDEX_BITS-1:0] v);
        logic [32:0] ext;
        ext = 33'(v);
        return (ext > 33'h0FFFF) ? 16'hFFFF : ext[15:0];
    endfunction

endpackage

// ----- rtl/csvft_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer front end
// Holds the configuration and the per-line parse state, classifies each
// input byte and pushes the results it causes as one packet.
// ----------------------------------------------------------------------------
module csvft_front
    import csvft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_in_line,
    output logic       o_push,
    output t_pkt       o_pkt
);

    logic [6:0]                  r_delim;
    logic [6:0]                  r_quote;
    logic                        r_inq;
    logic                        r_qp;
    logic                        r_bp;
    logic [1:0]                  r_left;
    logic                        r_drop;
    logic [FIELD_INDEX_BITS-1:0] r_cnt;

    logic                        n_inq;
    logic                        n_qp;
    logic                        n_bp;
    logic [1:0]                  n_left;
    logic                        n_drop;
    logic [FIELD_INDEX_BITS-1:0] n_cnt;
    t_pkt                        n_pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_quote <= QUOTE_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DELIMITER: r_delim <= i_cfg_data;
                CFG_QUOTE:     r_quote <= i_cfg_data;
                default:       r_delim <= r_delim;
            endcase
        end
    end

    always_comb begin
        logic [7:0] b;
        logic [1:0] k;
        logic       done;
        logic       err;
        logic       dend;
        logic       is_quote;
        b        = i_data_byte;
        k        = 2'd0;
        done     = 1'b0;
        err      = 1'b0;
        dend     = 1'b0;
        is_quote = (b == {1'b0, r_quote});
        n_inq    = r_inq;
        n_qp     = r_qp;
        n_bp     = r_bp;
        n_left   = r_left;
        n_drop   = r_drop;
        n_cnt    = r_cnt;
        n_pkt    = '0;
        n_pkt.field_number = sat_field(r_cnt);

        if (!r_drop) begin
            if (r_qp) begin
                n_qp = 1'b0;
                if (is_quote) begin
                    n_pkt.res[k] = '{out_byte: b, has_byte: 1'b1, field_end: 1'b0,
                                     utf8_error: 1'b0};
                    k    = k + 2'd1;
                    done = 1'b1;
                end else begin
                    n_inq = 1'b0;
                end
            end else if (r_bp) begin
                n_bp = 1'b0;
                if (is_quote || (b == BACKSLASH_BYTE)) begin
                    n_pkt.res[k] = '{out_byte: b, has_byte: 1'b1, field_end: 1'b0,
                                     utf8_error: 1'b0};
                    k    = k + 2'd1;
                    done = 1'b1;
                end else begin
                    n_pkt.res[k] = '{out_byte: BACKSLASH_BYTE, has_byte: 1'b1,
                                     field_end: 1'b0, utf8_error: 1'b0};
                    k = k + 2'd1;
                end
            end

            if (!done) begin
                if (r_left != 2'd0) begin
                    if ((b[7:6] != UTF8_CONT_TAG) || (i_last_in_line && (r_left > 2'd1))) begin
                        err = 1'b1;
                    end else begin
                        n_left = r_left - 2'd1;
                        n_pkt.res[k] = '{out_byte: b, has_byte: 1'b1, field_end: 1'b0,
                                         utf8_error: 1'b0};
                        k = k + 2'd1;
                    end
                end else if (b[7]) begin
                    if ((b >= UTF8_LEAD2_LO) && (b <= UTF8_LEAD2_HI)) begin
                        n_left = 2'd1;
                    end else if ((b >= UTF8_LEAD3_LO) && (b <= UTF8_LEAD3_HI)) begin
                        n_left = 2'd2;
                    end else if ((b >= UTF8_LEAD4_LO) && (b <= UTF8_LEAD4_HI)) begin
                        n_left = 2'd3;
                    end else begin
                        err = 1'b1;
                    end
                    if (!err && i_last_in_line) begin
                        err = 1'b1;
                    end
                    if (err) begin
                        n_left = r_left;
                    end else begin
                        n_pkt.res[k] = '{out_byte: b, has_byte: 1'b1, field_end: 1'b0,
                                         utf8_error: 1'b0};
                        k = k + 2'd1;
                    end
                end else if (is_quote) begin
                    if (n_inq) begin
                        n_qp = 1'b1;
                    end else begin
                        n_inq = 1'b1;
                    end
                end else if ((b == {1'b0, r_delim}) && !n_inq) begin
                    n_pkt.res[k] = '{out_byte: 8'd0, has_byte: 1'b0, field_end: 1'b1,
                                     utf8_error: 1'b0};
                    k    = k + 2'd1;
                    dend = 1'b1;
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else if (b == BACKSLASH_BYTE) begin
                    n_bp = 1'b1;
                end else begin
                    n_pkt.res[k] = '{out_byte: b, has_byte: 1'b1, field_end: 1'b0,
                                     utf8_error: 1'b0};
                    k = k + 2'd1;
                end
            end

            if (err) begin
                n_pkt.res[k] = '{out_byte: 8'd0, has_byte: 1'b0, field_end: 1'b0,
                                 utf8_error: 1'b1};
                k      = k + 2'd1;
                n_drop = 1'b1;
            end

            if (i_last_in_line && !err) begin
                if (n_bp) begin
                    n_pkt.res[k] = '{out_byte: BACKSLASH_BYTE, has_byte: 1'b1,
                                     field_end: 1'b0, utf8_error: 1'b0};
                    k = k + 2'd1;
                end
                if (!dend) begin
                    n_pkt.res[k] = '{out_byte: 8'd0, has_byte: 1'b0, field_end: 1'b1,
                                     utf8_error: 1'b0};
                    k = k + 2'd1;
                end
            end
        end

        if (i_last_in_line) begin
            n_inq  = 1'b0;
            n_qp   = 1'b0;
            n_bp   = 1'b0;
            n_left = 2'd0;
            n_drop = 1'b0;
            n_cnt  = '0;
        end
        n_pkt.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inq  <= 1'b0;
            r_qp   <= 1'b0;
            r_bp   <= 1'b0;
            r_left <= 2'd0;
            r_drop <= 1'b0;
            r_cnt  <= '0;
        end else if (i_accept) begin
            r_inq  <= n_inq;
            r_qp   <= n_qp;
            r_bp   <= n_bp;
            r_left <= n_left;
            r_drop <= n_drop;
            r_cnt  <= n_cnt;
        end
    end

    assign o_push = i_accept && (n_pkt.cnt != 2'd0);
    assign o_pkt  = n_pkt;

endmodule

// ----- rtl/csvft_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer packet queue
// Short first-in first-out queue of result packets between front and back.
// ----------------------------------------------------------------------------
module csvft_queue
    import csvft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    input  logic i_pop,
    output t_pkt o_pkt,
    output logic o_full,
    output logic o_nonempty
);

    t_pkt                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full     = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_pkt      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/csvft_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer back end
// Takes packets from the queue and presents their results one beat at a time
// from an output register.
// ----------------------------------------------------------------------------
module csvft_back
    import csvft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pkt        i_pkt,
    input  logic        i_q_nonempty,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_field_end,
    output logic [15:0] o_field_number,
    output logic        o_utf8_error,
    output logic        o_last
);

    logic       r_valid;
    t_pkt       r_pkt;
    logic [1:0] r_idx;
    logic       is_last;
    logic       taken;
    logic       load;
    t_res       cur;

    assign cur     = r_pkt.res[r_idx];
    assign is_last = (r_idx == 2'(r_pkt.cnt - 2'd1));
    assign taken   = i_pop && r_valid;
    assign load    = i_q_nonempty && (!r_valid || (taken && is_last));
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (taken) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pkt <= i_pkt;
        end
    end

    assign o_empty        = !r_valid;
    assign o_out_byte     = cur.out_byte;
    assign o_has_byte     = cur.has_byte;
    assign o_field_end    = cur.field_end;
    assign o_utf8_error   = cur.utf8_error;
    assign o_field_number = r_pkt.field_number;
    assign o_last         = is_last;

endmodule

// ----- rtl/csv_field_tokenizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer core
// Splits a byte stream of CSV lines into field content bytes and field end
// markers, with quoting, backslash escapes and UTF-8 checking.
// ----------------------------------------------------------------------------
// The block takes one input byte and gives one result per cycle unless
// stalled. Each byte is classified in the cycle it is pushed and causes zero
// to three results, which enter a four-packet queue; the output stage then
// presents them one beat each. Bytes that cause at most one result sustain
// one byte per cycle when the consumer pops every cycle; a byte with two or
// three results takes one output beat per result, so the input rate is
// bounded by the total number of results. The delimiter and quote registers
// are written through the configuration channel, which is always ready.
module csv_field_tokenizer_core
    import csvft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_in_line,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_field_end,
    output logic [15:0] o_field_number,
    output logic        o_utf8_error,
    output logic        o_last
);

    logic accept;
    logic f_push;
    t_pkt f_pkt;
    t_pkt q_pkt;
    logic q_full;
    logic q_nonempty;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    csvft_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_last_in_line (i_last_in_line),
        .o_push         (f_push),
        .o_pkt          (f_pkt)
    );

    csvft_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_push),
        .i_pkt      (f_pkt),
        .i_pop      (q_pop),
        .o_pkt      (q_pkt),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    csvft_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pkt          (q_pkt),
        .i_q_nonempty   (q_nonempty),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_has_byte     (o_has_byte),
        .o_field_end    (o_field_end),
        .o_field_number (o_field_number),
        .o_utf8_error   (o_utf8_error),
        .o_last         (o_last)
    );

endmodule

// ----- bench/tb_csv_field_tokenizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer core testbench
// Streams directed and random CSV lines through the core under several
// delimiter and quote settings and varying stalls on both sides. Each
// result beat is compared with a bit-exact software tokenizer.
// ----------------------------------------------------------------------------
module tb_csv_field_tokenizer_core;
    import csvft_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 6;
    localparam int PHASE_BYTES  = 70;
    localparam int SETTLE_CYCLE = 16;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [7:0] COMMA  = {1'b0, DELIM_RESET};
    localparam logic [7:0] DQUOTE = {1'b0, QUOTE_RESET};
    localparam logic [7:0] BSL    = BACKSLASH_BYTE;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        field_end;
        logic [15:0] field_number;
        logic        utf8_error;
        logic        last;
    } t_token;

    class token_tracker;
        logic [6:0]  sep_reg;
        logic [6:0]  quote_reg;
        bit          quoted;
        bit          close_pending;
        bit          escape_pending;
        bit [1:0]    cont_left;
        bit          skipping;
        bit [15:0]   field_idx;
        bit          err_hit;
        bit          sep_hit;
        t_token      step_tokens[$];
        t_token      tokens_due[$];
        int          mismatches;

        function new();
            sep_reg    = DELIM_RESET;
            quote_reg  = QUOTE_RESET;
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            quoted         = 1'b0;
            close_pending  = 1'b0;
            escape_pending = 1'b0;
            cont_left      = 2'd0;
            skipping       = 1'b0;
            field_idx      = 16'd0;
        endfunction

        function void set_register(t_cfg_index idx, logic [6:0] value);
            if (idx == CFG_DELIMITER) begin
                sep_reg = value;
            end else begin
                quote_reg = value;
            end
        endfunction

        function void add_token(logic [7:0] b, bit hb, bit fe, bit err);
            t_token t;
            if (step_tokens.size() >= RES_MAX) return;
            t.out_byte     = hb ? b : 8'h00;
            t.has_byte     = hb;
            t.field_end    = fe;
            t.field_number = field_idx;
            t.utf8_error   = err;
            t.last         = 1'b0;
            step_tokens.push_back(t);
        endfunction

        function void close_field();
            add_token(8'h00, 1'b0, 1'b1, 1'b0);
            if (field_idx != 16'hFFFF) field_idx++;
        endfunction

        function void flag_bad_utf8();
            add_token(8'h00, 1'b0, 1'b0, 1'b1);
            err_hit  = 1'b1;
            skipping = 1'b1;
        endfunction

        function void classify(logic [7:0] b, bit ln);
            bit [1:0] need;
            if (cont_left != 0) begin
                if (b[7:6] != UTF8_CONT_TAG || (ln && cont_left > 1)) begin
                    flag_bad_utf8();
                end else begin
                    cont_left--;
                    add_token(b, 1'b1, 1'b0, 1'b0);
                end
            end else if (b[7]) begin
                need = 2'd0;
                if (b >= UTF8_LEAD2_LO && b <= UTF8_LEAD2_HI) need = 2'd1;
                else if (b >= UTF8_LEAD3_LO && b <= UTF8_LEAD3_HI) need = 2'd2;
                else if (b >= UTF8_LEAD4_LO && b <= UTF8_LEAD4_HI) need = 2'd3;
                if (need == 0 || ln) begin
                    flag_bad_utf8();
                end else begin
                    cont_left = need;
                    add_token(b, 1'b1, 1'b0, 1'b0);
                end
            end else if (b == {1'b0, quote_reg}) begin
                if (quoted) close_pending = 1'b1;
                else quoted = 1'b1;
            end else if (b == {1'b0, sep_reg} && !quoted) begin
                close_field();
                sep_hit = 1'b1;
            end else if (b == BACKSLASH_BYTE) begin
                escape_pending = 1'b1;
            end else begin
                add_token(b, 1'b1, 1'b0, 1'b0);
            end
        endfunction

        function void tokenize_byte(logic [7:0] b, logic ln);
            bit     done;
            t_token t;
            step_tokens.delete();
            err_hit = 1'b0;
            sep_hit = 1'b0;
            done    = 1'b0;
            if (!skipping) begin
                if (close_pending) begin
                    close_pending = 1'b0;
                    if (b == {1'b0, quote_reg}) begin
                        add_token(b, 1'b1, 1'b0, 1'b0);
                        done = 1'b1;
                    end else begin
                        quoted = 1'b0;
                    end
                end else if (escape_pending) begin
                    escape_pending = 1'b0;
                    if (b == {1'b0, quote_reg} || b == BACKSLASH_BYTE) begin
                        add_token(b, 1'b1, 1'b0, 1'b0);
                        done = 1'b1;
                    end else begin
                        add_token(BACKSLASH_BYTE, 1'b1, 1'b0, 1'b0);
                    end
                end
                if (!done) classify(b, ln);
                if (ln && !err_hit) begin
                    if (escape_pending) add_token(BACKSLASH_BYTE, 1'b1, 1'b0, 1'b0);
                    if (!sep_hit) close_field();
                end
            end
            if (ln) clear_line();
            foreach (step_tokens[i]) begin
                t      = step_tokens[i];
                t.last = (i == step_tokens.size() - 1);
                tokens_due.push_back(t);
            end
        endfunction

        function string fmt_token(t_token t);
            return $sformatf("byte=%02h has=%0d end=%0d field=%0d err=%0d last=%0d",
                             t.out_byte, t.has_byte, t.field_end, t.field_number,
                             t.utf8_error, t.last);
        endfunction

        function void check_token(t_token got);
            t_token want;
            if (tokens_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %s", fmt_token(got));
            end else begin
                want = tokens_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %s", fmt_token(want));
                        $display("          actual   %s", fmt_token(got));
                    end
                end
            end
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        i_cfg_index    = 1'b0;
    logic [6:0]  i_cfg_data     = 7'd0;
    logic        push           = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_last_in_line = 1'b0;
    logic        pop            = 1'b0;
    logic        o_cfg_ready;
    logic        full;
    logic        empty;
    logic [7:0]  o_out_byte;
    logic        o_has_byte;
    logic        o_field_end;
    logic [15:0] o_field_number;
    logic        o_utf8_error;
    logic        o_last;

    token_tracker book = new();
    int           send_idle_pct = 22;
    int           recv_idle_pct = 72;
    bit           hold_req      = 1'b0;
    bit           hold_done     = 1'b0;
    int           cycles        = 0;

    csv_field_tokenizer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_last_in_line (i_last_in_line),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_has_byte     (o_has_byte),
        .o_field_end    (o_field_end),
        .o_field_number (o_field_number),
        .o_utf8_error   (o_utf8_error),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin : watch
        t_token got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                book.set_register(t_cfg_index'(i_cfg_index), i_cfg_data);
            if (push && !full)
                book.tokenize_byte(i_data_byte, i_last_in_line);
            if (pop && !empty) begin
                got.out_byte     = o_out_byte;
                got.has_byte     = o_has_byte;
                got.field_end    = o_field_end;
                got.field_number = o_field_number;
                got.utf8_error   = o_utf8_error;
                got.last         = o_last;
                book.check_token(got);
            end
        end
    end

    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_registers(input logic [6:0] sep, input logic [6:0] quo);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_DELIMITER;
        i_cfg_data  <= sep;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_QUOTE;
        i_cfg_data  <= quo;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic ln);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_data_byte    <= b;
        i_last_in_line <= ln;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_line(input t_byte_q line);
        foreach (line[i]) send_byte(line[i], i == line.size() - 1);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLE) @(posedge i_clk);
    endtask

    // Quoting, doubled quotes and escapes; multi-byte UTF-8 with a trailing
    // delimiter; bad lead bytes, a bad continuation and a truncated sequence;
    // an escaped backslash and a quote left pending at the end of the line.
    task automatic run_directed();
        t_byte_q line;
        line = '{8'h00, COMMA, DQUOTE, DQUOTE, DQUOTE, COMMA, DQUOTE, COMMA,
                 BSL, DQUOTE, BSL, 8'h7F, BSL};
        send_line(line);
        line = '{8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'hBF, COMMA};
        send_line(line);
        line = '{8'h80, 8'h41};
        send_line(line);
        line = '{8'hC3, 8'h41};
        send_line(line);
        line = '{8'hE2, 8'h82};
        send_line(line);
        line = '{BSL, BSL, DQUOTE, 8'h71, DQUOTE};
        send_line(line);
        line = '{8'hFF, 8'hF5, 8'hC0};
        send_line(line);
    endtask

    function automatic t_byte_q random_line(input logic [6:0] sep, input logic [6:0] quo);
        t_byte_q line;
        int      n;
        int      pick;
        int      seq_len;
        n = $urandom_range(1, 10);
        if ($urandom_range(19) == 0) n = $urandom_range(20, 40);
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                line.push_back(8'($urandom_range(32, 126)));
            end else if (pick < 55) begin
                line.push_back({1'b0, sep});
            end else if (pick < 67) begin
                line.push_back({1'b0, quo});
            end else if (pick < 75) begin
                line.push_back(BSL);
            end else if (pick < 92) begin
                seq_len = $urandom_range(2, 4);
                unique case (seq_len)
                    2: line.push_back(8'($urandom_range(UTF8_LEAD2_LO, UTF8_LEAD2_HI)));
                    3: line.push_back(8'($urandom_range(UTF8_LEAD3_LO, UTF8_LEAD3_HI)));
                    default: line.push_back(8'($urandom_range(UTF8_LEAD4_LO, UTF8_LEAD4_HI)));
                endcase
                repeat (seq_len - 1) line.push_back({UTF8_CONT_TAG, 6'($urandom_range(63))});
            end else begin
                line.push_back(8'($urandom_range(255)));
            end
        end
        if (line.size() > 1 && $urandom_range(19) == 0) void'(line.pop_back());
        return line;
    endfunction

    initial begin : stimulus
        logic [6:0] sep_set   [PHASES] = '{7'd44, 7'd9, 7'd0, 7'd127, 7'd92, 7'd59};
        logic [6:0] quote_set [PHASES] = '{7'd34, 7'd39, 7'd127, 7'd0, 7'd92, 7'd59};
        t_byte_q    line;
        int         sent;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_registers(DELIM_RESET, QUOTE_RESET);
        run_directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            if (phase < 2) begin
                send_idle_pct = 22;
                recv_idle_pct = 72;
            end else if (phase < 4) begin
                send_idle_pct = 72;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_registers(sep_set[phase], quote_set[phase]);
            if (phase == 4) hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                line = random_line(sep_set[phase], quote_set[phase]);
                send_line(line);
                sent += line.size();
            end
        end
        wait_drained();
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/csvft_pkg.sv
rtl/csvft_front.sv
rtl/csvft_queue.sv
rtl/csvft_back.sv
rtl/csv_field_tokenizer_core.sv
bench/tb_csv_field_tokenizer_core.sv
